FILE: design/kvcrb_pkg.sv
// kvcrb_pkg: shared types, codes, widths and helper functions of the kv cache ring buffer
// no dependencies; imported by every module of the block

package kvcrb_pkg;

	// fixed field widths
	localparam int WORD_BITS  = 32;
	localparam int ACT_W      = 2;
	localparam int TOK_W      = 6;
	localparam int HEAD_W     = 3;
	localparam int KEEP_W     = 7;
	localparam int HELD_W     = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// register field widths as seen on the config port
	localparam int CAP_FIELD_W = 7;
	localparam int HC_FIELD_W  = 4;
	localparam int HW_FIELD_W  = 7;

	// queue depths
	localparam int CMDQ_DEPTH = 4;
	localparam int OUTQ_DEPTH = 4;

	// default sizing of the store
	localparam int DEF_RING_SLOTS   = 64;
	localparam int DEF_MAX_HEADS    = 8;
	localparam int DEF_MAX_HEAD_DIM = 64;

	// action codes on the input channel
	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_EVICT = 2'd2
	} act_t;

	// decoded operation carried to the back end
	typedef enum logic [1:0] {
		OP_PUSH,
		OP_READ,
		OP_EVICT
	} op_t;

	// config register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAPACITY = 2'd0,
		CFG_HEADS    = 2'd1,
		CFG_WIDTH    = 2'd2
	} cfg_idx_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_SUM,
		S_RUN
	} state_t;

	// one classified command
	typedef struct packed {
		op_t                  op;
		logic [WORD_BITS-1:0] key;
		logic [WORD_BITS-1:0] value;
		logic [TOK_W-1:0]     tok;
		logic [HEAD_W-1:0]    head;
		logic [KEEP_W-1:0]    keep;
	} cmd_t;

	// one result item
	typedef struct packed {
		logic [WORD_BITS-1:0] key;
		logic [WORD_BITS-1:0] value;
		logic                 last;
		logic                 status;
		logic [HELD_W-1:0]    held;
	} res_t;

	// bits needed to hold the value v
	function automatic int unsigned bits_for(int unsigned v);
		int unsigned n;
		n = 1;
		while ((v >> n) != 0) n++;
		return n;
	endfunction

	// larger of two widths
	function automatic int unsigned max_w(int unsigned a, int unsigned b);
		return (a > b) ? a : b;
	endfunction

	// zero reads as one, above the limit reads as the limit
	function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

endpackage

FILE: design/kvcrb_fifo.sv
// kvcrb_fifo: small register queue with valid/ready on both sides and a fill level output
// depends on kvcrb_pkg (bits_for)

module kvcrb_fifo import kvcrb_pkg::*; #(
	parameter type ITEM_T = logic,
	parameter int  DEPTH  = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  ITEM_T                      in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output ITEM_T                      out_item,
	output logic [bits_for(DEPTH)-1:0] level
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = bits_for(DEPTH);

	ITEM_T             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [LVL_W-1:0]  level_q;
	logic              push;
	logic              pop;

	// handshake and head item
	assign in_ready  = (level_q != LVL_W'(DEPTH));
	assign out_valid = (level_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign level     = level_q;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_item;
	end

	// pointers and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      level_q <= level_q + 1'b1;
			else if (pop && !push) level_q <= level_q - 1'b1;
		end
	end

endmodule

FILE: design/kvcrb_front.sv
// kvcrb_front: input stage; takes items, decodes the action and drops unknown ones
// depends on kvcrb_pkg (act_t, op_t, cmd_t)

module kvcrb_front import kvcrb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [ACT_W-1:0]     action,
	input  logic [WORD_BITS-1:0] key_word,
	input  logic [WORD_BITS-1:0] value_word,
	input  logic [TOK_W-1:0]     token_index,
	input  logic [HEAD_W-1:0]    head_index,
	input  logic [KEEP_W-1:0]    keep_count,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output cmd_t                 cmd
);

	logic known;
	op_t  op_dec;
	logic vld_s1;
	cmd_t cmd_s1;

	// action decoder
	always_comb begin
		known  = 1'b1;
		op_dec = OP_PUSH;
		unique case (act_t'(action))
			ACT_PUSH:  op_dec = OP_PUSH;
			ACT_READ:  op_dec = OP_READ;
			ACT_EVICT: op_dec = OP_EVICT;
			default:   known = 1'b0;
		endcase
	end

	// one register stage toward the command queue
	assign in_ready  = !vld_s1 || cmd_ready;
	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid && known;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= '{op: op_dec, key: key_word, value: value_word,
				tok: token_index, head: head_index, keep: keep_count};
		end
	end

endmodule

FILE: design/kvcrb_back.sv
// kvcrb_back: config registers, ring state, word store and the read sequencer
// depends on kvcrb_pkg; fed by the command queue, feeds the result queue

module kvcrb_back import kvcrb_pkg::*; #(
	parameter int RING_SLOTS   = DEF_RING_SLOTS,
	parameter int MAX_HEADS    = DEF_MAX_HEADS,
	parameter int MAX_HEAD_DIM = DEF_MAX_HEAD_DIM
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [CFG_IDX_W-1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0]           cfg_data,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  cmd_t                            cmd,
	input  logic [bits_for(OUTQ_DEPTH)-1:0] oq_level,
	input  logic                            oq_ready,
	output logic                            res_valid,
	output res_t                            res
);

	localparam int DEPTH  = RING_SLOTS * MAX_HEADS * MAX_HEAD_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CAP_W  = max_w(CAP_FIELD_W, bits_for(RING_SLOTS));
	localparam int CAP_W1 = CAP_W + 1;
	localparam int HC_W   = max_w(HC_FIELD_W, bits_for(MAX_HEADS));
	localparam int HW_W   = HW_FIELD_W;
	localparam int ST_W   = HC_W + HW_W;
	localparam int PROD_W = CAP_W + ST_W;
	localparam int HOFF_W = HEAD_W + HW_W;

	// config registers
	logic [CAP_W-1:0] cap_q;
	logic [HC_W-1:0]  heads_q;
	logic [HW_W-1:0]  hwid_q;
	logic [ST_W-1:0]  stride_q;

	// ring state
	logic [CAP_W-1:0]  oldest_q;
	logic [CAP_W-1:0]  count_q;
	logic [CAP_W-1:0]  wr_slot_q;
	logic [ADDR_W-1:0] wr_base_q;
	logic [ST_W-1:0]   fill_q;

	// read sequencer
	state_t             state_q;
	state_t             state_d;
	logic [CAP_W-1:0]   rd_slot_q;
	logic [HEAD_W-1:0]  rd_head_q;
	logic [ADDR_W-1:0]  rd_prod_q;
	logic [ADDR_W-1:0]  rd_hoff_q;
	logic [ADDR_W-1:0]  rd_addr_q;
	logic [HW_W-1:0]    rd_left_q;
	logic [HELD_W-1:0]  held_q;

	// store and read stage
	logic [WORD_BITS-1:0] key_mem_q [DEPTH];
	logic [WORD_BITS-1:0] value_mem_q [DEPTH];
	logic                 iss_s1;
	logic                 last_s1;
	logic                 err_s1;
	logic [HELD_W-1:0]    held_s1;
	logic [WORD_BITS-1:0] key_rd_s1;
	logic [WORD_BITS-1:0] value_rd_s1;

	// strobes from the sequencer
	logic do_push;
	logic do_evict;
	logic do_rdisp;
	logic do_issue;
	logic credit;
	logic cfg_hit;

	// config write values
	logic [CAP_W-1:0] new_cap;
	logic [HC_W-1:0]  new_heads;
	logic [HW_W-1:0]  new_hwid;

	// push datapath
	logic [ADDR_W-1:0] wr_addr;
	logic [ST_W-1:0]   fill_inc;
	logic              commit;
	logic              full;
	logic [CAP_W-1:0]  oldest_inc;
	logic [CAP_W-1:0]  cnt_base;
	logic [CAP_W-1:0]  slot_inc;
	logic [ADDR_W-1:0] base_inc;

	// evict and read dispatch datapath
	logic [CAP_W-1:0]  keep_w;
	logic [CAP_W1-1:0] ev_sum;
	logic [CAP_W-1:0]  ev_oldest;
	logic [CAP_W-1:0]  tok_w;
	logic [HC_W-1:0]   head_w;
	logic              rd_bad;
	logic [CAP_W1-1:0] rd_sum;
	logic [CAP_W-1:0]  rd_slot;
	logic [PROD_W-1:0] mul_slot;
	logic [HOFF_W-1:0] mul_head;

	// register writes, clamped
	assign new_cap   = CAP_W'(clamp_reg(32'(cfg_data), RING_SLOTS));
	assign new_heads = HC_W'(clamp_reg(32'(cfg_data[HC_FIELD_W-1:0]), MAX_HEADS));
	assign new_hwid  = HW_W'(clamp_reg(32'(cfg_data), MAX_HEAD_DIM));
	assign cfg_hit   = cfg_valid && (cfg_index == CFG_CAPACITY || cfg_index == CFG_HEADS ||
		cfg_index == CFG_WIDTH);

	// room in the result queue for one more read, counting the one in flight
	assign credit = (32'(oq_level) + 32'(iss_s1)) < 32'(OUTQ_DEPTH);

	// push: element address, commit and full-ring overwrite
	assign wr_addr    = wr_base_q + ADDR_W'(fill_q);
	assign fill_inc   = fill_q + 1'b1;
	assign commit     = (fill_inc >= stride_q);
	assign full       = (fill_q == '0) && (count_q >= cap_q);
	assign oldest_inc = (oldest_q + 1'b1 == cap_q) ? '0 : oldest_q + 1'b1;
	assign cnt_base   = full ? cap_q - 1'b1 : count_q;
	assign slot_inc   = (wr_slot_q + 1'b1 == cap_q) ? '0 : wr_slot_q + 1'b1;
	assign base_inc   = (slot_inc == '0) ? '0 : wr_base_q + ADDR_W'(stride_q);

	// evict: the filling slot stays put, so the new oldest is keep slots behind it
	assign keep_w    = CAP_W'(cmd.keep);
	assign ev_sum    = CAP_W1'(wr_slot_q) + CAP_W1'(cap_q) - CAP_W1'(keep_w);
	assign ev_oldest = (wr_slot_q >= keep_w) ? wr_slot_q - keep_w : CAP_W'(ev_sum);

	// read: range check and physical slot
	assign tok_w   = CAP_W'(cmd.tok);
	assign head_w  = HC_W'(cmd.head);
	assign rd_bad  = (tok_w >= count_q) || (head_w >= heads_q);
	assign rd_sum  = CAP_W1'(oldest_q) + CAP_W1'(tok_w);
	assign rd_slot = (rd_sum >= CAP_W1'(cap_q)) ? CAP_W'(rd_sum - CAP_W1'(cap_q)) : CAP_W'(rd_sum);

	// slot base and head offset products
	assign mul_slot = PROD_W'(rd_slot_q) * PROD_W'(stride_q);
	assign mul_head = HOFF_W'(rd_head_q) * HOFF_W'(hwid_q);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// sequencer next state and strobes
	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		do_push   = 1'b0;
		do_evict  = 1'b0;
		do_rdisp  = 1'b0;
		do_issue  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						OP_PUSH: begin
							cmd_ready = 1'b1;
							do_push   = 1'b1;
						end
						OP_EVICT: begin
							cmd_ready = 1'b1;
							do_evict  = 1'b1;
						end
						OP_READ: begin
							if (credit) begin
								cmd_ready = 1'b1;
								do_rdisp  = 1'b1;
								if (!rd_bad) state_d = S_MUL;
							end
						end
						default: ;
					endcase
				end
			end
			S_MUL: state_d = S_SUM;
			S_SUM: state_d = S_RUN;
			S_RUN: begin
				if (credit) begin
					do_issue = 1'b1;
					if (rd_left_q == HW_W'(1)) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// config registers and ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_W'(RING_SLOTS);
			heads_q   <= HC_W'(MAX_HEADS);
			hwid_q    <= HW_W'(MAX_HEAD_DIM);
			stride_q  <= ST_W'(MAX_HEADS * MAX_HEAD_DIM);
			oldest_q  <= '0;
			count_q   <= '0;
			wr_slot_q <= '0;
			wr_base_q <= '0;
			fill_q    <= '0;
		end else if (cfg_hit) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CAPACITY: cap_q <= new_cap;
				CFG_HEADS: begin
					heads_q  <= new_heads;
					stride_q <= ST_W'(new_heads) * ST_W'(hwid_q);
				end
				CFG_WIDTH: begin
					hwid_q   <= new_hwid;
					stride_q <= ST_W'(heads_q) * ST_W'(new_hwid);
				end
				default: ;
			endcase
			oldest_q  <= '0;
			count_q   <= '0;
			wr_slot_q <= '0;
			wr_base_q <= '0;
			fill_q    <= '0;
		end else if (do_push) begin
			if (full) oldest_q <= oldest_inc;
			if (commit) begin
				fill_q    <= '0;
				count_q   <= cnt_base + 1'b1;
				wr_slot_q <= slot_inc;
				wr_base_q <= base_inc;
			end else begin
				fill_q  <= fill_inc;
				count_q <= cnt_base;
			end
		end else if (do_evict) begin
			if (keep_w < count_q) begin
				oldest_q <= ev_oldest;
				count_q  <= keep_w;
			end
		end
	end

	// read setup and address walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_left_q <= '0;
		end else if (state_q == S_SUM) begin
			rd_left_q <= hwid_q;
		end else if (do_issue) begin
			rd_left_q <= rd_left_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_rdisp) begin
			rd_slot_q <= rd_slot;
			rd_head_q <= cmd.head;
			held_q    <= count_q[HELD_W-1:0];
		end
		if (state_q == S_MUL) begin
			rd_prod_q <= ADDR_W'(mul_slot);
			rd_hoff_q <= ADDR_W'(mul_head);
		end
		if (state_q == S_SUM) rd_addr_q <= rd_prod_q + rd_hoff_q;
		else if (do_issue)    rd_addr_q <= rd_addr_q + 1'b1;
	end

	// word store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (do_push) begin
			key_mem_q[wr_addr]   <= cmd.key;
			value_mem_q[wr_addr] <= cmd.value;
		end
		if (do_issue) begin
			key_rd_s1   <= key_mem_q[rd_addr_q];
			value_rd_s1 <= value_mem_q[rd_addr_q];
		end
	end

	// result stage: a store read or an out-of-range error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) iss_s1 <= 1'b0;
		else         iss_s1 <= do_issue || (do_rdisp && rd_bad);
	end

	always_ff @(posedge clk) begin
		if (do_rdisp) begin
			last_s1 <= 1'b1;
			err_s1  <= 1'b1;
			held_s1 <= count_q[HELD_W-1:0];
		end else if (do_issue) begin
			last_s1 <= (rd_left_q == HW_W'(1));
			err_s1  <= 1'b0;
			held_s1 <= held_q;
		end
	end

	assign res_valid = iss_s1;

	always_comb begin
		res.key    = err_s1 ? '0 : key_rd_s1;
		res.value  = err_s1 ? '0 : value_rd_s1;
		res.last   = last_s1;
		res.status = err_s1;
		res.held   = held_s1;
	end

	// checks
	a_fill_in_token: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < stride_q)
		else $error("fill position beyond token size");

	a_count_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("token count above capacity");

	a_slot_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		wr_slot_q < cap_q)
		else $error("write slot outside the ring");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> oq_ready)
		else $error("result pushed into a full result queue");

	a_run_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (rd_left_q != '0))
		else $error("read run with no words left");

endmodule

FILE: design/kv_cache_ring_buffer.sv
// kv_cache_ring_buffer: top level; input stage, command queue, back end, result queue
// depends on kvcrb_pkg, kvcrb_front, kvcrb_fifo, kvcrb_back

// Ring store of attention key/value tokens. Push and evict items run at one per cycle
// while no read holds the back end: they pass a decode register and a four-entry
// command queue into the back end. A read registers its slot, multiplies slot and
// head offsets, adds them into the address, then streams head_width word pairs at one
// per cycle while the result queue has room, from the store's single read port; an
// out-of-range read gives its error result in the next cycle. Results pass a four-entry
// queue, so the back end keeps running while the consumer stalls, up to that depth. The
// store is not cleared at reset and needs no clearing pass; only committed tokens are
// ever read. A config write to a valid index empties the ring; cfg_ready is always high.
module kv_cache_ring_buffer import kvcrb_pkg::*; #(
	parameter int RING_SLOTS   = DEF_RING_SLOTS,
	parameter int MAX_HEADS    = DEF_MAX_HEADS,
	parameter int MAX_HEAD_DIM = DEF_MAX_HEAD_DIM
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [ACT_W-1:0]      action,
	input  logic [WORD_BITS-1:0]  key_word,
	input  logic [WORD_BITS-1:0]  value_word,
	input  logic [TOK_W-1:0]      token_index,
	input  logic [HEAD_W-1:0]     head_index,
	input  logic [KEEP_W-1:0]     keep_count,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [WORD_BITS-1:0]  key_out,
	output logic [WORD_BITS-1:0]  value_out,
	output logic                  last,
	output logic                  status,
	output logic [HELD_W-1:0]     tokens_held,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic                            fe_valid;
	logic                            fe_ready;
	cmd_t                            fe_cmd;
	logic                            cq_valid;
	logic                            cq_ready;
	cmd_t                            cq_cmd;
	logic [bits_for(CMDQ_DEPTH)-1:0] cq_level;
	logic                            res_valid;
	logic                            oq_ready;
	res_t                            res;
	logic [bits_for(OUTQ_DEPTH)-1:0] oq_level;
	res_t                            oq_res;

	// config writes are always accepted
	assign cfg_ready = 1'b1;

	// input stage
	kvcrb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.key_word    (key_word),
		.value_word  (value_word),
		.token_index (token_index),
		.head_index  (head_index),
		.keep_count  (keep_count),
		.cmd_valid   (fe_valid),
		.cmd_ready   (fe_ready),
		.cmd         (fe_cmd)
	);

	// command queue between front and back
	kvcrb_fifo #(
		.ITEM_T (cmd_t),
		.DEPTH  (CMDQ_DEPTH)
	) u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fe_valid),
		.in_ready  (fe_ready),
		.in_item   (fe_cmd),
		.out_valid (cq_valid),
		.out_ready (cq_ready),
		.out_item  (cq_cmd),
		.level     (cq_level)
	);

	// ring state, store and read sequencer
	kvcrb_back #(
		.RING_SLOTS   (RING_SLOTS),
		.MAX_HEADS    (MAX_HEADS),
		.MAX_HEAD_DIM (MAX_HEAD_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cq_valid),
		.cmd_ready (cq_ready),
		.cmd       (cq_cmd),
		.oq_level  (oq_level),
		.oq_ready  (oq_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	// result queue toward the consumer
	kvcrb_fifo #(
		.ITEM_T (res_t),
		.DEPTH  (OUTQ_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (oq_ready),
		.in_item   (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (oq_res),
		.level     (oq_level)
	);

	// result fields
	assign key_out     = oq_res.key;
	assign value_out   = oq_res.value;
	assign last        = oq_res.last;
	assign status      = oq_res.status;
	assign tokens_held = oq_res.held;

endmodule
